// File: rtl/ppperm_pkg.sv
`default_nettype none
package ppperm_pkg;

  localparam int MAX_ITEMS = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int VAL_W     = $clog2(MAX_ITEMS + 1);
  localparam int CNT_W     = 6;

  localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(8);
  localparam logic [CNT_W-1:0] MIN_COUNT   = CNT_W'(2);
  localparam logic [CNT_W-1:0] MAX_COUNT   = CNT_W'(MAX_ITEMS);

  // control broadcast to every list cell
  typedef struct packed {
    logic             reload;
    logic             shift;
    logic [IDX_W-1:0] digit;
    logic [VAL_W-1:0] load_n;
  } cell_ctrl_t;

  function automatic logic [VAL_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    logic [VAL_W-1:0] r;
    if (v < MIN_COUNT) begin
      r = VAL_W'(MIN_COUNT);
    end else if (v > MAX_COUNT) begin
      r = VAL_W'(MAX_COUNT);
    end else begin
      r = VAL_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ppperm_cell.sv
`default_nettype none
module ppperm_cell (
  input  wire logic                             clk,
  input  wire ppperm_pkg::cell_ctrl_t           ctrl,
  input  wire logic [ppperm_pkg::IDX_W-1:0]     cell_idx,
  input  wire logic [ppperm_pkg::VAL_W-1:0]     right_val,
  output logic      [ppperm_pkg::VAL_W-1:0]     value,
  output logic      [ppperm_pkg::VAL_W-1:0]     hit_val
);

  logic [ppperm_pkg::VAL_W-1:0] value_r;
  logic [ppperm_pkg::VAL_W-1:0] value_nxt;
  logic [ppperm_pkg::VAL_W-1:0] idx_ext;

  assign idx_ext = ppperm_pkg::VAL_W'(cell_idx);

  always_comb begin
    value_nxt = value_r;
    if (ctrl.reload) begin
      value_nxt = (idx_ext < ctrl.load_n) ? idx_ext + ppperm_pkg::VAL_W'(1)
                                          : '0;
    end else if (ctrl.shift && (cell_idx >= ctrl.digit)) begin
      // close the gap left by the removed entry
      value_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value   = value_r;
  assign hit_val = (cell_idx == ctrl.digit) ? value_r : '0;

endmodule
`default_nettype wire

// File: rtl/pair_prefs_to_permutation_top.sv
// Latency: the word closing a block gives out_valid on the next cycle; on the
//   last block of a ranking the final item follows the cycle after the first is taken.
// Throughput: one pref word per cycle; after the last block the input stalls
//   until the first result word is taken, and it also stalls
//   while a waiting result word is held by out_stall.
// Reset (sync, active low): count 8, list cells reload with 1..n, no sweep.
`default_nettype none
module pair_prefs_to_permutation_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [ppperm_pkg::CNT_W-1:0]      cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_pref_bit,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [ppperm_pkg::VAL_W-1:0]      out_item,
  output logic                                   out_last_of_seq
);

  localparam int N = ppperm_pkg::MAX_ITEMS;
  localparam int IW = ppperm_pkg::IDX_W;
  localparam int VW = ppperm_pkg::VAL_W;

  logic [ppperm_pkg::CNT_W-1:0] count_r;
  logic [IW-1:0]                pos_r, pos_nxt;
  logic [IW-1:0]                bit_r, bit_nxt;
  logic [IW-1:0]                ones_r, ones_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [VW-1:0]                out_item_r, out_item_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         pend_valid_r, pend_valid_nxt;
  logic [VW-1:0]                pend_item_r, pend_item_nxt;

  logic [VW-1:0]                n_eff;
  logic [VW-1:0]                block_len;
  logic [IW-1:0]                ones_sum;
  logic                         accept, out_take, block_end, seq_end, restart;
  logic [VW-1:0]                sel_item, final_item;
  ppperm_pkg::cell_ctrl_t       ctrl;

  logic [VW-1:0] cell_val [N];
  logic [VW-1:0] cell_hit [N];

  assign n_eff     = ppperm_pkg::clamp_count(count_r);
  assign block_len = n_eff - VW'(pos_r) - VW'(1);
  assign ones_sum  = ones_r + IW'(in_pref_bit);
  assign block_end = (VW'(bit_r) + VW'(1)) >= block_len;
  assign seq_end   = (VW'(pos_r) + VW'(2)) >= n_eff;

  assign in_stall  = pend_valid_r | (out_valid_r & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign out_take  = out_valid_r & ~out_stall;
  assign restart   = ~rst_n | cfg_wr_en | (accept & block_end & seq_end);

  always_comb begin
    ctrl.reload = restart;
    ctrl.shift  = accept & block_end;
    ctrl.digit  = ones_sum;
    if (!rst_n) begin
      ctrl.load_n = ppperm_pkg::clamp_count(ppperm_pkg::RESET_COUNT);
    end else if (cfg_wr_en) begin
      ctrl.load_n = ppperm_pkg::clamp_count(cfg_wr_data);
    end else begin
      ctrl.load_n = n_eff;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [VW-1:0] right;
    if (k == N - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = cell_val[k+1];
    end
    ppperm_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (IW'(k)),
      .right_val (right),
      .value     (cell_val[k]),
      .hit_val   (cell_hit[k])
    );
  end

  always_comb begin
    sel_item = '0;
    for (int k = 0; k < N; k++) begin
      sel_item = sel_item | cell_hit[k];
    end
  end

  // two entries live on the last block: the survivor is the one not picked
  assign final_item = (ones_sum == '0) ? cell_val[1] : cell_val[0];

  always_comb begin
    pos_nxt  = pos_r;
    bit_nxt  = bit_r;
    ones_nxt = ones_r;
    if (cfg_wr_en) begin
      pos_nxt  = '0;
      bit_nxt  = '0;
      ones_nxt = '0;
    end else if (accept) begin
      if (block_end) begin
        pos_nxt  = seq_end ? '0 : pos_r + IW'(1);
        bit_nxt  = '0;
        ones_nxt = '0;
      end else begin
        bit_nxt  = bit_r + IW'(1);
        ones_nxt = ones_sum;
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    out_last_nxt   = out_last_r;
    pend_valid_nxt = pend_valid_r;
    pend_item_nxt  = pend_item_r;
    if (accept && block_end) begin
      out_valid_nxt  = 1'b1;
      out_item_nxt   = sel_item;
      out_last_nxt   = 1'b0;
      pend_valid_nxt = seq_end;
      pend_item_nxt  = final_item;
    end else if (out_take) begin
      if (pend_valid_r) begin
        out_item_nxt   = pend_item_r;
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= ppperm_pkg::RESET_COUNT;
      pos_r        <= '0;
      bit_r        <= '0;
      ones_r       <= '0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      pos_r        <= pos_nxt;
      bit_r        <= bit_nxt;
      ones_r       <= ones_nxt;
      out_valid_r  <= out_valid_nxt;
      out_last_r   <= out_last_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    pend_item_r <= pend_item_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_item        = out_item_r;
  assign out_last_of_seq = out_last_r;

`ifndef SYNTHESIS
  a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("pending final word without a word in the output register");

  a_last_block_pends: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && block_end && seq_end) |=> (pend_valid_r && out_valid_r && !out_last_r))
    else $error("last block did not queue the final item");

  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> !pend_valid_r)
    else $error("final item shown while another word pending");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((VW'(pos_r) + VW'(2)) <= n_eff) && (ones_r <= bit_r))
    else $error("position or ones count out of range");
`endif

endmodule
`default_nettype wire
